### rtl/stsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stsc_pkg;

  localparam int KW_NUM      = 7;
  localparam int KW_TRUE_IDX = 4;
  localparam logic [KW_NUM-1:0] KW_ALL = '1;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_INT   = 3'd1;
  localparam logic [2:0] MODE_DOT   = 3'd2;
  localparam logic [2:0] MODE_FLOAT = 3'd3;
  localparam logic [2:0] MODE_STR   = 3'd4;
  localparam logic [2:0] MODE_WORD  = 3'd5;

  localparam logic [4:0] KIND_END      = 5'd0;
  localparam logic [4:0] KIND_INT      = 5'd1;
  localparam logic [4:0] KIND_FLOAT    = 5'd2;
  localparam logic [4:0] KIND_STR      = 5'd3;
  localparam logic [4:0] KIND_IDENT    = 5'd4;
  localparam logic [4:0] KIND_KW_INT   = 5'd5;
  localparam logic [4:0] KIND_KW_FLOAT = 5'd6;
  localparam logic [4:0] KIND_KW_STR   = 5'd7;
  localparam logic [4:0] KIND_KW_BOOL  = 5'd8;
  localparam logic [4:0] KIND_KW_BVAL  = 5'd9;
  localparam logic [4:0] KIND_KW_SAY   = 5'd10;
  localparam logic [4:0] KIND_SYM_BASE = 5'd11;

  localparam logic [7:0] KW_TEXT [0:KW_NUM-1][0:7] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
    '{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"S", "A", "Y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [0:KW_NUM-1] = '{3'd3, 3'd5, 3'd6, 3'd4, 3'd4, 3'd5, 3'd3};
  localparam logic [4:0] KW_KIND [0:KW_NUM-1] = '{
    KIND_KW_INT, KIND_KW_FLOAT, KIND_KW_STR, KIND_KW_BOOL, KIND_KW_BVAL, KIND_KW_BVAL,
    KIND_KW_SAY
  };

  typedef struct packed {
    logic       is_digit;
    logic       is_alpha;
    logic       is_under;
    logic       is_space;
    logic       is_quote;
    logic       is_dot;
    logic       is_sym;
    logic [3:0] sym_idx;
  } stsc_class_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        bval;
    logic        ovf;
  } stsc_tok_t;

  typedef struct packed {
    logic [4:0] kind;
    logic       bval;
  } stsc_kw_res_t;

  // keywords whose character at idx equals c
  function automatic logic [KW_NUM-1:0] kw_hit(input logic [7:0] c, input logic [2:0] idx);
    logic [KW_NUM-1:0] hit;
    hit = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      hit[k] = (idx < KW_LEN[k]) && (KW_TEXT[k][idx] == c);
    end
    return hit;
  endfunction

  // later keywords take precedence
  function automatic stsc_kw_res_t kw_resolve(input logic [KW_NUM-1:0] cand,
                                              input logic [2:0] len3);
    stsc_kw_res_t r;
    r.kind = KIND_IDENT;
    r.bval = 1'b0;
    for (int k = 0; k < KW_NUM; k++) begin
      if (cand[k] && (len3 == KW_LEN[k])) begin
        r.kind = KW_KIND[k];
        r.bval = (k == KW_TRUE_IDX);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/stsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stsc_front #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [7:0]               in_char_byte,
  input  wire logic                     in_final_byte,
  input  wire logic                     accept,
  output stsc_pkg::stsc_class_t         cls,
  output logic      [POSITION_BITS-1:0] pos,
  output logic      [POSITION_BITS-1:0] pos_next,
  output logic                          sat_old,
  output logic                          sat_new
);
  import stsc_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     sat_r, sat_nxt;
  logic                     at_max;

  assign at_max   = (pos_r == POS_MAX);
  assign pos      = pos_r;
  assign pos_next = at_max ? POS_MAX : pos_r + POS_ONE;
  assign sat_old  = sat_r;
  assign sat_new  = sat_r | at_max;

  always_comb begin
    pos_nxt = pos_r;
    sat_nxt = sat_r;
    if (accept) begin
      pos_nxt = in_final_byte ? '0 : pos_next;
      sat_nxt = in_final_byte ? 1'b0 : sat_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sat_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      sat_r <= sat_nxt;
    end
  end

  // byte classes
  always_comb begin
    cls          = '0;
    cls.is_digit = (in_char_byte >= "0") && (in_char_byte <= "9");
    cls.is_alpha = ((in_char_byte >= "a") && (in_char_byte <= "z")) ||
                   ((in_char_byte >= "A") && (in_char_byte <= "Z"));
    cls.is_under = (in_char_byte == "_");
    cls.is_space = (in_char_byte == " ") || (in_char_byte == 8'h0A) ||
                   (in_char_byte == 8'h09) || (in_char_byte == 8'h0D);
    cls.is_quote = (in_char_byte == 8'h22);
    cls.is_dot   = (in_char_byte == ".");
    cls.is_sym   = 1'b1;
    unique case (in_char_byte)
      "+":     cls.sym_idx = 4'd0;
      "-":     cls.sym_idx = 4'd1;
      "*":     cls.sym_idx = 4'd2;
      "/":     cls.sym_idx = 4'd3;
      "=":     cls.sym_idx = 4'd4;
      "(":     cls.sym_idx = 4'd5;
      ")":     cls.sym_idx = 4'd6;
      ",":     cls.sym_idx = 4'd7;
      ";":     cls.sym_idx = 4'd8;
      default: cls.is_sym  = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/stsc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module stsc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic                  rd_valid,
  output logic      [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_FULL);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/stsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stsc_back #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     head_valid,
  input  wire logic [7:0]               head_char,
  input  wire logic                     head_fin,
  input  wire stsc_pkg::stsc_class_t    head_cls,
  input  wire logic [POSITION_BITS-1:0] head_pos,
  input  wire logic [POSITION_BITS-1:0] head_pos_next,
  input  wire logic                     head_sat_old,
  input  wire logic                     head_sat_new,
  output logic                          head_pop,
  output stsc_pkg::stsc_tok_t           out_tok,
  output logic                          out_run_end,
  output logic                          out_valid,
  input  wire logic                     out_take
);
  import stsc_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_SEVEN = POSITION_BITS'(7);

  function automatic logic [15:0] to16(input logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic logic [2:0] small3(input logic [POSITION_BITS-1:0] v);
    return (v < POS_SEVEN) ? v[2:0] : 3'd7;
  endfunction

  logic [2:0]               mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] begin_r, begin_nxt;
  logic [KW_NUM-1:0]        cand_r, cand_nxt;
  logic [3:0]               done_r, done_nxt;
  logic                     out_valid_r, out_valid_nxt;
  stsc_tok_t                out_tok_r;
  logic                     out_run_end_r;

  logic [2:0]               mode1;
  logic [POSITION_BITS-1:0] begin1;
  logic [KW_NUM-1:0]        cand1;
  logic                     fresh;
  logic [POSITION_BITS-1:0] span_p, dspan_p, span_e, dspan_e;
  stsc_kw_res_t             kw_a, kw_c;
  stsc_tok_t                tok_a, tok_b, tok_c, tok_d, tok_sel;
  logic [3:0]               slot_v, rem, sel;
  logic                     has_tok, last_tok, out_can, emit, take_i;

  assign span_p  = (head_pos >= begin_r) ? head_pos - begin_r : '0;
  assign dspan_p = (head_pos > begin_r) ? head_pos - begin_r - POS_ONE : '0;

  // scan step for the head byte; slots a..d in output order
  always_comb begin
    mode1  = mode_r;
    begin1 = begin_r;
    cand1  = cand_r;
    fresh  = 1'b0;
    slot_v = '0;
    kw_a   = kw_resolve(cand_r, small3(span_p));
    tok_a  = '{kind: KIND_INT, start: to16(begin_r), length: to16(span_p),
               bval: 1'b0, ovf: head_sat_old};
    tok_b  = '{kind: KIND_SYM_BASE + 5'(head_cls.sym_idx), start: to16(head_pos),
               length: 16'd1, bval: 1'b0, ovf: head_sat_old};

    unique case (mode_r)
      MODE_INT: begin
        if (head_cls.is_dot) begin
          mode1 = MODE_DOT;
        end else if (!head_cls.is_digit) begin
          slot_v[0] = 1'b1;
          fresh     = 1'b1;
        end
      end
      MODE_DOT: begin
        if (head_cls.is_digit) begin
          mode1 = MODE_FLOAT;
        end else begin
          slot_v[0]    = 1'b1;
          tok_a.length = to16(dspan_p);
          fresh        = 1'b1;
        end
      end
      MODE_FLOAT: begin
        if (!head_cls.is_digit) begin
          slot_v[0]  = 1'b1;
          tok_a.kind = KIND_FLOAT;
          fresh      = 1'b1;
        end
      end
      MODE_WORD: begin
        if (head_cls.is_alpha || head_cls.is_digit || head_cls.is_under) begin
          cand1 = cand_r & kw_hit(head_char, small3(span_p));
        end else begin
          slot_v[0]  = 1'b1;
          tok_a.kind = kw_a.kind;
          tok_a.bval = kw_a.bval;
          fresh      = 1'b1;
        end
      end
      MODE_STR: begin
        if (head_cls.is_quote) begin
          slot_v[0]  = 1'b1;
          tok_a.kind = KIND_STR;
          mode1      = MODE_IDLE;
        end
      end
      default: fresh = 1'b1;
    endcase

    if (fresh) begin
      mode1 = MODE_IDLE;
      priority if (head_cls.is_quote) begin
        begin1 = (head_pos == POS_MAX) ? POS_MAX : head_pos + POS_ONE;
        mode1  = MODE_STR;
      end else if (head_cls.is_digit) begin
        begin1 = head_pos;
        mode1  = MODE_INT;
      end else if (head_cls.is_alpha || head_cls.is_under) begin
        begin1 = head_pos;
        cand1  = KW_ALL & kw_hit(head_char, 3'd0);
        mode1  = MODE_WORD;
      end else if (head_cls.is_sym) begin
        slot_v[1] = 1'b1;
      end
    end

    span_e  = (head_pos_next >= begin1) ? head_pos_next - begin1 : '0;
    dspan_e = (head_pos_next > begin1) ? head_pos_next - begin1 - POS_ONE : '0;
    kw_c    = kw_resolve(cand1, small3(span_e));
    tok_c   = '{kind: KIND_INT, start: to16(begin1), length: to16(span_e),
                bval: 1'b0, ovf: head_sat_new};
    unique case (mode1)
      MODE_DOT:   tok_c.length = to16(dspan_e);
      MODE_FLOAT: tok_c.kind   = KIND_FLOAT;
      MODE_STR:   tok_c.kind   = KIND_STR;
      MODE_WORD: begin
        tok_c.kind = kw_c.kind;
        tok_c.bval = kw_c.bval;
      end
      default: tok_c.kind = KIND_INT;
    endcase
    slot_v[2] = head_fin && (mode1 != MODE_IDLE);
    slot_v[3] = head_fin;
    tok_d     = '{kind: KIND_END, start: to16(head_pos_next), length: 16'd0,
                  bval: 1'b0, ovf: head_sat_new};
  end

  assign rem      = slot_v & ~done_r;
  assign sel      = rem & (~rem + 4'd1);
  assign has_tok  = (rem != 4'd0);
  assign last_tok = ((rem & ~sel) == 4'd0);
  assign take_i   = out_take && out_valid_r;
  assign out_can  = !out_valid_r || take_i;
  assign emit     = head_valid && has_tok && out_can;
  assign head_pop = head_valid && (!has_tok || (out_can && last_tok));

  always_comb begin
    priority if (sel[0]) begin
      tok_sel = tok_a;
    end else if (sel[1]) begin
      tok_sel = tok_b;
    end else if (sel[2]) begin
      tok_sel = tok_c;
    end else begin
      tok_sel = tok_d;
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    begin_nxt     = begin_r;
    cand_nxt      = cand_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    if (take_i) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      done_nxt      = done_r | sel;
    end
    if (head_pop) begin
      done_nxt = '0;
      if (head_fin) begin
        mode_nxt  = MODE_IDLE;
        begin_nxt = '0;
        cand_nxt  = KW_ALL;
      end else begin
        mode_nxt  = mode1;
        begin_nxt = begin1;
        cand_nxt  = cand1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      begin_r     <= '0;
      cand_r      <= KW_ALL;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      begin_r     <= begin_nxt;
      cand_r      <= cand_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tok_r     <= tok_sel;
      out_run_end_r <= last_tok;
    end
  end

  assign out_tok     = out_tok_r;
  assign out_run_end = out_run_end_r;
  assign out_valid   = out_valid_r;

  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_tok_r.kind == KIND_END) |-> out_run_end_r)
    else $error("end token without run_end");

  a_final_resets_scan: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop && head_fin |=> (mode_r == MODE_IDLE) && (cand_r == KW_ALL))
    else $error("scan state not cleared after final byte");

  a_done_within_slots: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ((done_r & ~slot_v) == 4'd0))
    else $error("sent mask outside token slots");

  a_at_most_three: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ($countones(slot_v) <= 3))
    else $error("more than three tokens for one byte");

endmodule

`default_nettype wire

### rtl/script_token_scanner_core.sv
// script_token_scanner_core: byte-serial scanner for a small scripting language.
// Input channel: present in_char_byte / in_final_byte with push; a byte is taken
// at a rising edge with push high and full low. Mark the last byte of a text
// with in_final_byte; the offsets then restart at 0 for the next text.
// Result channel: while empty is low, the oldest token is on the out_ ports;
// assert pop to take it. out_run_end marks the last token of one byte.
// A byte is written into the queue; its first token then goes into the output register.
// Throughput: one byte per cycle while each byte gives at most one token and the
// receiver pops every token; a byte that gives several tokens holds the token stage
// until each has gone, since the single output register takes one token per cycle.
// Bytes that give no token retire without waiting on the output register.
// A two-entry queue sits between the classifier and the token stage, and the
// output register frees on the same edge it is popped, so a stalled receiver
// only fills the queue and then raises full; nothing is lost.
// Reset (rst_n low, synchronous) empties queue and output and returns the
// scanner to its start state at offset 0.
`timescale 1ns / 1ps
`default_nettype none

module script_token_scanner_core #(
  parameter int POSITION_BITS = 16,
  parameter int QUEUE_DEPTH   = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic        in_final_byte,
  input  wire logic        push,
  output logic             full,
  output logic [4:0]       out_token_kind,
  output logic [15:0]      out_text_start,
  output logic [15:0]      out_text_length,
  output logic             out_bool_value,
  output logic             out_overflow,
  output logic             out_run_end,
  output logic             empty,
  input  wire logic        pop
);
  import stsc_pkg::*;

  localparam int QW = 2 * POSITION_BITS + 2 + 1 + 8 + $bits(stsc_class_t);

  logic                     accept;
  stsc_class_t              f_cls, h_cls;
  logic [POSITION_BITS-1:0] f_pos, f_pos_next, h_pos, h_pos_next;
  logic                     f_sat_old, f_sat_new, h_sat_old, h_sat_new;
  logic [7:0]               h_char;
  logic                     h_fin;
  logic [QW-1:0]            q_wr, q_rd;
  logic                     q_valid, q_pop;
  stsc_tok_t                tok;
  logic                     out_valid;

  assign accept = push && !full;

  stsc_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char_byte (in_char_byte),
    .in_final_byte(in_final_byte),
    .accept       (accept),
    .cls          (f_cls),
    .pos          (f_pos),
    .pos_next     (f_pos_next),
    .sat_old      (f_sat_old),
    .sat_new      (f_sat_new)
  );

  assign q_wr = {f_pos, f_pos_next, f_sat_old, f_sat_new, in_final_byte, in_char_byte, f_cls};
  assign {h_pos, h_pos_next, h_sat_old, h_sat_new, h_fin, h_char, h_cls} = q_rd;

  stsc_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (q_wr),
    .full    (full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_rd)
  );

  stsc_back #(
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_valid),
    .head_char    (h_char),
    .head_fin     (h_fin),
    .head_cls     (h_cls),
    .head_pos     (h_pos),
    .head_pos_next(h_pos_next),
    .head_sat_old (h_sat_old),
    .head_sat_new (h_sat_new),
    .head_pop     (q_pop),
    .out_tok      (tok),
    .out_run_end  (out_run_end),
    .out_valid    (out_valid),
    .out_take     (pop)
  );

  assign empty           = !out_valid;
  assign out_token_kind  = tok.kind;
  assign out_text_start  = tok.start;
  assign out_text_length = tok.length;
  assign out_bool_value  = tok.bval;
  assign out_overflow    = tok.ovf;

endmodule

`default_nettype wire
